// ----- hdl/rsep_pkg.sv -----
package rsep_pkg;

  localparam int BYTE_W    = 8;
  localparam int DATA_W    = 64;
  localparam int PARITY_W  = 32;
  localparam int ROW_COUNT = 4;
  localparam int CFG_W     = 64;
  localparam int ADDR_W    = 6;
  localparam int IDX_LSB   = 3;

  localparam int MAX_DATA_DEF   = 8;
  localparam int MAX_PARITY_DEF = 4;

  localparam int COUNT_D_W = 4;
  localparam int COUNT_P_W = 3;
  localparam int POLY_W    = 9;

  localparam logic [COUNT_D_W-1:0] DATA_COUNT_RST   = 4'd6;
  localparam logic [COUNT_P_W-1:0] PARITY_COUNT_RST = 3'd3;
  localparam logic [POLY_W-1:0]    FIELD_POLY_RST   = 9'h11D;

  typedef logic [BYTE_W-1:0] gf_byte_t;

  typedef enum logic [2:0] {
    REG_DATA_COUNT   = 3'd0,
    REG_PARITY_COUNT = 3'd1,
    REG_COEFF_ROW_0  = 3'd2,
    REG_COEFF_ROW_1  = 3'd3,
    REG_COEFF_ROW_2  = 3'd4,
    REG_COEFF_ROW_3  = 3'd5,
    REG_FIELD_POLY   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [COUNT_D_W-1:0]                data_count;
    logic [COUNT_P_W-1:0]                parity_count;
    logic [ROW_COUNT-1:0][DATA_W-1:0]    coeff;
    logic [POLY_W-1:0]                   field_poly;
  } rsep_cfg_t;

  typedef struct packed {
    logic     active;
    gf_byte_t poly_low;
  } cell_ctl_t;

  function automatic gf_byte_t gf_mul(input gf_byte_t a, input gf_byte_t b,
                                      input gf_byte_t poly_low);
    gf_byte_t acc;
    gf_byte_t aa;
    acc = '0;
    aa  = a;
    for (int i = 0; i < BYTE_W; i++) begin
      if (b[i]) begin
        acc = acc ^ aa;
      end
      if (aa[BYTE_W-1]) begin
        aa = {aa[BYTE_W-2:0], 1'b0} ^ poly_low;
      end else begin
        aa = {aa[BYTE_W-2:0], 1'b0};
      end
    end
    return acc;
  endfunction

endpackage

// ----- hdl/rsep_if.sv -----
interface rsep_in_if;
  logic                          valid;
  logic                          ready;
  logic [rsep_pkg::DATA_W-1:0]   data_column;
  logic [rsep_pkg::PARITY_W-1:0] prior_parity;
  modport source(output valid, data_column, prior_parity, input ready);
  modport sink(input valid, data_column, prior_parity, output ready);
endinterface

interface rsep_out_if;
  logic                          valid;
  logic                          ready;
  logic [rsep_pkg::PARITY_W-1:0] parity_column;
  modport source(output valid, parity_column, input ready);
  modport sink(input valid, parity_column, output ready);
endinterface

// ----- hdl/rsep_regs.sv -----
module rsep_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rsep_pkg::ADDR_W-1:0] paddr,
  input  logic [rsep_pkg::CFG_W-1:0]  pwdata,
  output logic [rsep_pkg::CFG_W-1:0]  prdata,
  output logic                        pready,
  output rsep_pkg::rsep_cfg_t         cfg
);

  rsep_pkg::rsep_cfg_t cfg_r;
  rsep_pkg::rsep_cfg_t cfg_nxt;
  rsep_pkg::reg_idx_t  idx;
  logic                wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = rsep_pkg::reg_idx_t'(paddr[rsep_pkg::ADDR_W-1:rsep_pkg::IDX_LSB]);
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        rsep_pkg::REG_DATA_COUNT: begin
          cfg_nxt.data_count = pwdata[rsep_pkg::COUNT_D_W-1:0];
        end
        rsep_pkg::REG_PARITY_COUNT: begin
          cfg_nxt.parity_count = pwdata[rsep_pkg::COUNT_P_W-1:0];
        end
        rsep_pkg::REG_COEFF_ROW_0: cfg_nxt.coeff[0] = pwdata;
        rsep_pkg::REG_COEFF_ROW_1: cfg_nxt.coeff[1] = pwdata;
        rsep_pkg::REG_COEFF_ROW_2: cfg_nxt.coeff[2] = pwdata;
        rsep_pkg::REG_COEFF_ROW_3: cfg_nxt.coeff[3] = pwdata;
        rsep_pkg::REG_FIELD_POLY: begin
          cfg_nxt.field_poly = pwdata[rsep_pkg::POLY_W-1:0];
        end
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      rsep_pkg::REG_DATA_COUNT:   prdata = rsep_pkg::CFG_W'(cfg_r.data_count);
      rsep_pkg::REG_PARITY_COUNT: prdata = rsep_pkg::CFG_W'(cfg_r.parity_count);
      rsep_pkg::REG_COEFF_ROW_0:  prdata = cfg_r.coeff[0];
      rsep_pkg::REG_COEFF_ROW_1:  prdata = cfg_r.coeff[1];
      rsep_pkg::REG_COEFF_ROW_2:  prdata = cfg_r.coeff[2];
      rsep_pkg::REG_COEFF_ROW_3:  prdata = cfg_r.coeff[3];
      rsep_pkg::REG_FIELD_POLY:   prdata = rsep_pkg::CFG_W'(cfg_r.field_poly);
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.data_count   <= rsep_pkg::DATA_COUNT_RST;
      cfg_r.parity_count <= rsep_pkg::PARITY_COUNT_RST;
      cfg_r.coeff        <= '0;
      cfg_r.field_poly   <= rsep_pkg::FIELD_POLY_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- hdl/rsep_cell.sv -----
module rsep_cell #(
  parameter int LANES = rsep_pkg::MAX_PARITY_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  rsep_pkg::cell_ctl_t                      ctl,
  input  logic [LANES-1:0][rsep_pkg::BYTE_W-1:0]   coeff,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [rsep_pkg::DATA_W-1:0]              in_data,
  input  logic [LANES-1:0][rsep_pkg::BYTE_W-1:0]   in_acc,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic [rsep_pkg::DATA_W-1:0]              out_data,
  output logic [LANES-1:0][rsep_pkg::BYTE_W-1:0]   out_acc
);

  logic                                   valid_r;
  logic                                   valid_nxt;
  logic [rsep_pkg::DATA_W-1:0]            data_r;
  logic [LANES-1:0][rsep_pkg::BYTE_W-1:0] acc_r;
  logic [LANES-1:0][rsep_pkg::BYTE_W-1:0] acc_nxt;

  assign in_ready  = !valid_r || out_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;
  assign out_valid = valid_r;
  assign out_data  = data_r;
  assign out_acc   = acc_r;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      acc_nxt[l] = in_acc[l];
      if (ctl.active) begin
        acc_nxt[l] = in_acc[l] ^ rsep_pkg::gf_mul(coeff[l],
                                                  in_data[rsep_pkg::BYTE_W-1:0],
                                                  ctl.poly_low);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      acc_r  <= acc_nxt;
      data_r <= {{rsep_pkg::BYTE_W{1'b0}},
                 in_data[rsep_pkg::DATA_W-1:rsep_pkg::BYTE_W]};
    end
  end

endmodule

// ----- hdl/rs_erasure_parity_encode.sv -----
// Reed-Solomon erasure parity encoder over GF(2^8).
// Input channel in_chan carries one byte column per item: data_column holds
// byte j of data shard j, prior_parity the parity byte held so far for each
// parity row. Output channel out_chan returns parity_column, one item per
// input item, in order: each active row's prior byte XORed with the GF
// products of that row's coefficients and the active data bytes; inactive
// rows read as zero.
// Coefficients, shard and row counts and the reduction polynomial sit in an
// APB register file (64-bit data, register i at byte address 8*i). Write
// them only while no item is in flight.
// The datapath is a chain of MAX_DATA cells, one per data shard, each
// folding its shard's products into the running parity and registering it.
// Each accepted item is registered in every cell in turn, and out_chan.valid
// rises once the item sits in the last cell. Throughput is one item per cycle
// while out_chan.ready stays high; the GF multiply in each cell is
// combinational. Each cell holds its item while the next one stalls, so
// input keeps being taken until every cell is full.
// Reset (synchronous, active low) empties the chain and restores the
// register defaults: 6 data shards, 3 parity rows, zero coefficients, 0x11D.
module rs_erasure_parity_encode #(
  parameter int MAX_DATA   = rsep_pkg::MAX_DATA_DEF,
  parameter int MAX_PARITY = rsep_pkg::MAX_PARITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  rsep_in_if.sink                     in_chan,
  rsep_out_if.source                  out_chan,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rsep_pkg::ADDR_W-1:0] paddr,
  input  logic [rsep_pkg::CFG_W-1:0]  pwdata,
  output logic [rsep_pkg::CFG_W-1:0]  prdata,
  output logic                        pready
);

  localparam int LANES = (MAX_PARITY < rsep_pkg::ROW_COUNT) ? MAX_PARITY
                                                            : rsep_pkg::ROW_COUNT;

  rsep_pkg::rsep_cfg_t                             cfg;
  logic [LANES-1:0]                                lane_active;
  logic [MAX_DATA-1:0]                             shard_active;
  logic [MAX_DATA:0]                               valid_s;
  logic [MAX_DATA:0]                               ready_s;
  logic [rsep_pkg::DATA_W-1:0]                     data_s [MAX_DATA+1];
  logic [LANES-1:0][rsep_pkg::BYTE_W-1:0]          acc_s  [MAX_DATA+1];

  rsep_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign valid_s[0]     = in_chan.valid;
  assign in_chan.ready  = ready_s[0];
  assign data_s[0]      = in_chan.data_column;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    assign lane_active[l] = cfg.parity_count > rsep_pkg::COUNT_P_W'(l);
    assign acc_s[0][l]    = lane_active[l]
                            ? in_chan.prior_parity[rsep_pkg::BYTE_W*l +: rsep_pkg::BYTE_W]
                            : '0;
  end

  for (genvar j = 0; j < MAX_DATA; j++) begin : g_cell
    rsep_pkg::cell_ctl_t                    ctl;
    logic [LANES-1:0][rsep_pkg::BYTE_W-1:0] coeff;

    assign shard_active[j] = cfg.data_count > rsep_pkg::COUNT_D_W'(j);
    assign ctl.active      = shard_active[j];
    assign ctl.poly_low    = cfg.field_poly[rsep_pkg::BYTE_W-1:0];

    for (genvar l = 0; l < LANES; l++) begin : g_coeff
      assign coeff[l] = lane_active[l]
                        ? cfg.coeff[l][rsep_pkg::BYTE_W*j +: rsep_pkg::BYTE_W]
                        : '0;
    end

    rsep_cell #(
      .LANES (LANES)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .coeff     (coeff),
      .in_valid  (valid_s[j]),
      .in_ready  (ready_s[j]),
      .in_data   (data_s[j]),
      .in_acc    (acc_s[j]),
      .out_valid (valid_s[j+1]),
      .out_ready (ready_s[j+1]),
      .out_data  (data_s[j+1]),
      .out_acc   (acc_s[j+1])
    );
  end

  assign out_chan.valid         = valid_s[MAX_DATA];
  assign ready_s[MAX_DATA]      = out_chan.ready;
  assign out_chan.parity_column = rsep_pkg::PARITY_W'(acc_s[MAX_DATA]);

  a_accept_enters_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> valid_s[1])
    else $error("accepted item did not enter first cell");

  a_empty_output_not_blocking: assert property (@(posedge clk) disable iff (!rst_n)
    !valid_s[MAX_DATA] |-> in_chan.ready)
    else $error("input stalled with output stage empty");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (&valid_s[MAX_DATA:1]))
    else $error("input stalled while a cell is empty");

endmodule
